FILE: rtl/wpmc_pkg.sv
// water pump mode controller: shared types, codes, reset values and the mode table
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package wpmc_pkg;

	localparam int unsigned PRES_W = 14;
	localparam int unsigned TIME_W = 32;
	localparam int unsigned MS_W   = 20;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 20;

	typedef enum logic [1:0] {
		REQ_TICK       = 2'd0,
		REQ_ACTIVATE   = 2'd1,
		REQ_DEACTIVATE = 2'd2
	} req_e_t;

	localparam logic [1:0] PRESS_M1 = 2'd0;
	localparam logic [1:0] PRESS_M2 = 2'd1;
	localparam logic [1:0] PRESS_M3 = 2'd2;

	localparam logic [3:0] MODE_NONE = 4'd0;
	localparam logic [3:0] MODE_L1   = 4'd1;
	localparam logic [3:0] MODE_L2   = 4'd2;
	localparam logic [3:0] MODE_L3   = 4'd3;
	localparam logic [3:0] MODE_L4   = 4'd4;
	localparam logic [3:0] MODE_E1A  = 4'd5;
	localparam logic [3:0] MODE_E1B  = 4'd6;
	localparam logic [3:0] MODE_E1C  = 4'd7;
	localparam logic [3:0] MODE_E2A  = 4'd8;
	localparam logic [3:0] MODE_E2B  = 4'd9;
	localparam logic [3:0] MODE_E2C  = 4'd10;
	localparam logic [3:0] MODE_E3   = 4'd11;
	localparam logic [3:0] MODE_C1   = 4'd12;
	localparam logic [3:0] MODE_C2   = 4'd13;

	localparam logic [CFG_IDX_W-1:0] CFG_DEMAND_PRES = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FAULT_TIME  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_SWITCH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PUMP_ON     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PUMP_OFF    = 3'd4;

	localparam logic [PRES_W-1:0] RST_DEMAND_PRES = 14'd2000;
	localparam logic [MS_W-1:0]   RST_FAULT_TIME  = 20'd30000;
	localparam logic [MS_W-1:0]   RST_MIN_SWITCH  = 20'd5000;
	localparam logic [PRES_W-1:0] RST_PUMP_ON     = 14'd2000;
	localparam logic [PRES_W-1:0] RST_PUMP_OFF    = 14'd3500;

	typedef struct packed {
		logic [PRES_W-1:0] demand_pres;
		logic [MS_W-1:0]   fault_time;
		logic [MS_W-1:0]   min_switch;
		logic [PRES_W-1:0] pump_on;
		logic [PRES_W-1:0] pump_off;
	} cfg_t;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [3:0]        mode_code;
		logic [TIME_W-1:0] now_ms;
		logic [PRES_W-1:0] pressure_mbar;
		logic              safety_alert;
	} item_t;

	typedef struct packed {
		logic       valve_one;
		logic       valve_two;
		logic       pump_drive;
		logic [1:0] press_select;
		logic [3:0] mode_now;
		logic       fault_cut;
	} res_t;

	typedef struct packed {
		logic       v1;
		logic       v2;
		logic [1:0] press;
	} entry_t;

	// valve settings and pressure switch mode for each mode code
	function automatic entry_t mode_entry(input logic [3:0] code);
		entry_t e;
		e = '{v1: 1'b0, v2: 1'b0, press: PRESS_M1};
		unique case (code) inside
			MODE_L1, MODE_E1A, MODE_C2: e = '{v1: 1'b1, v2: 1'b0, press: PRESS_M1};
			MODE_L2, MODE_E3:           e = '{v1: 1'b1, v2: 1'b1, press: PRESS_M1};
			MODE_L3, MODE_L4, MODE_E2A, MODE_C1:
				e = '{v1: 1'b0, v2: 1'b1, press: PRESS_M1};
			MODE_E1B: e = '{v1: 1'b1, v2: 1'b0, press: PRESS_M2};
			MODE_E1C: e = '{v1: 1'b1, v2: 1'b0, press: PRESS_M3};
			MODE_E2B: e = '{v1: 1'b0, v2: 1'b1, press: PRESS_M2};
			MODE_E2C: e = '{v1: 1'b0, v2: 1'b1, press: PRESS_M3};
			default:  e = '{v1: 1'b0, v2: 1'b0, press: PRESS_M1};
		endcase
		return e;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/water_pump_mode_controller_unit.sv
// top level of the water pump mode controller: input and result registers
// depends on wpmc_pkg, wpmc_cfg, wpmc_core
//
// channel | handshake              | payload
// in      | in_valid / in_ready    | req_type mode_code now_ms pressure_mbar safety_alert
// out     | out_valid / out_ready  | valve_one valve_two pump_drive press_select
//         |                        | mode_now fault_cut
// cfg     | cfg_valid / cfg_ready  | cfg_index cfg_data
//
// one item per cycle unless the output stalls; each result is registered
// the state update is a loop between the input register and the state flops
// a stalled result holds in the result register while the input register still fills
// cfg_ready is always high; reset restores the register defaults and clears all state
`timescale 1ns / 1ps
`default_nettype none
module water_pump_mode_controller_unit (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [1:0]                       req_type,
	input  wire logic [3:0]                       mode_code,
	input  wire logic [31:0]                      now_ms,
	input  wire logic [13:0]                      pressure_mbar,
	input  wire logic                             safety_alert,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic                                  valve_one,
	output logic                                  valve_two,
	output logic                                  pump_drive,
	output logic [1:0]                            press_select,
	output logic [3:0]                            mode_now,
	output logic                                  fault_cut,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [wpmc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [wpmc_pkg::CFG_DATA_W-1:0]  cfg_data
);

	wpmc_pkg::cfg_t   cfg;
	wpmc_pkg::item_t  item_s1;
	logic             valid_s1;
	wpmc_pkg::res_t   res;
	wpmc_pkg::res_t   res_s2;
	logic             valid_s2;
	logic             advance;

	assign cfg_ready = 1'b1;

	wpmc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.req_type      <= req_type;
			item_s1.mode_code     <= mode_code;
			item_s1.now_ms        <= now_ms;
			item_s1.pressure_mbar <= pressure_mbar;
			item_s1.safety_alert  <= safety_alert;
		end
	end

	wpmc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item_s1),
		.step   (advance),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_valid    = valid_s2;
	assign valve_one    = res_s2.valve_one;
	assign valve_two    = res_s2.valve_two;
	assign pump_drive   = res_s2.pump_drive;
	assign press_select = res_s2.press_select;
	assign mode_now     = res_s2.mode_now;
	assign fault_cut    = res_s2.fault_cut;

endmodule
`default_nettype wire

FILE: rtl/wpmc_cfg.sv
// configuration register file for the water pump mode controller
// depends on wpmc_pkg
`timescale 1ns / 1ps
`default_nettype none
module wpmc_cfg (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             wr_en,
	input  wire logic [wpmc_pkg::CFG_IDX_W-1:0]   wr_index,
	input  wire logic [wpmc_pkg::CFG_DATA_W-1:0]  wr_data,
	output wpmc_pkg::cfg_t                        cfg
);

	wpmc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.demand_pres <= wpmc_pkg::RST_DEMAND_PRES;
			cfg_q.fault_time  <= wpmc_pkg::RST_FAULT_TIME;
			cfg_q.min_switch  <= wpmc_pkg::RST_MIN_SWITCH;
			cfg_q.pump_on     <= wpmc_pkg::RST_PUMP_ON;
			cfg_q.pump_off    <= wpmc_pkg::RST_PUMP_OFF;
		end else if (wr_en) begin
			unique case (wr_index)
				wpmc_pkg::CFG_DEMAND_PRES:
					cfg_q.demand_pres <= wr_data[wpmc_pkg::PRES_W-1:0];
				wpmc_pkg::CFG_FAULT_TIME:
					cfg_q.fault_time <= wr_data[wpmc_pkg::MS_W-1:0];
				wpmc_pkg::CFG_MIN_SWITCH:
					cfg_q.min_switch <= wr_data[wpmc_pkg::MS_W-1:0];
				wpmc_pkg::CFG_PUMP_ON:
					cfg_q.pump_on <= wr_data[wpmc_pkg::PRES_W-1:0];
				wpmc_pkg::CFG_PUMP_OFF:
					cfg_q.pump_off <= wr_data[wpmc_pkg::PRES_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

FILE: rtl/wpmc_core.sv
// controller state and the combinational step logic for one item
// depends on wpmc_pkg
`timescale 1ns / 1ps
`default_nettype none
module wpmc_core (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire wpmc_pkg::cfg_t cfg,
	input  wire wpmc_pkg::item_t item,
	input  wire logic           step,
	output wpmc_pkg::res_t      res
);

	logic [3:0]                    mode_q, mode_d;
	logic                          pump_q, pump_d;
	logic                          v1_q, v1_d;
	logic                          v2_q, v2_d;
	logic [1:0]                    press_q, press_d;
	logic [wpmc_pkg::TIME_W-1:0]   last_sw_q, last_sw_d;
	logic                          demand_q, demand_d;
	logic [wpmc_pkg::TIME_W-1:0]   dem_start_q, dem_start_d;
	logic                          cut;

	logic [3:0]                    code;
	wpmc_pkg::entry_t              new_ent;
	wpmc_pkg::entry_t              cur_ent;
	logic [wpmc_pkg::TIME_W-1:0]   dem_age;
	logic [wpmc_pkg::TIME_W-1:0]   sw_age;
	logic                          fault_due;
	logic                          may_switch;
	logic                          extraction;

	// codes past the table count as no mode
	assign code    = (item.mode_code > wpmc_pkg::MODE_C2) ? wpmc_pkg::MODE_NONE
	                                                      : item.mode_code;
	assign new_ent = wpmc_pkg::mode_entry(code);
	assign cur_ent = wpmc_pkg::mode_entry(mode_q);

	// wrapping time differences
	assign dem_age    = item.now_ms - dem_start_q;
	assign sw_age     = item.now_ms - last_sw_q;
	assign fault_due  = dem_age > {{(wpmc_pkg::TIME_W-wpmc_pkg::MS_W){1'b0}}, cfg.fault_time};
	assign may_switch = sw_age > {{(wpmc_pkg::TIME_W-wpmc_pkg::MS_W){1'b0}}, cfg.min_switch};
	assign extraction = (mode_q >= wpmc_pkg::MODE_E1A) && (mode_q <= wpmc_pkg::MODE_E3);

	always_comb begin
		mode_d      = mode_q;
		pump_d      = pump_q;
		v1_d        = v1_q;
		v2_d        = v2_q;
		press_d     = press_q;
		last_sw_d   = last_sw_q;
		demand_d    = demand_q;
		dem_start_d = dem_start_q;
		cut         = 1'b0;
		unique case (wpmc_pkg::req_e_t'(item.req_type))
			wpmc_pkg::REQ_ACTIVATE: begin
				if (code != mode_q) begin
					pump_d      = 1'b0;
					v1_d        = new_ent.v1;
					v2_d        = new_ent.v2;
					press_d     = new_ent.press;
					last_sw_d   = item.now_ms;
					demand_d    = 1'b0;
					dem_start_d = '0;
					mode_d      = code;
				end
			end
			wpmc_pkg::REQ_DEACTIVATE: begin
				pump_d  = 1'b0;
				v1_d    = 1'b0;
				v2_d    = 1'b0;
				press_d = wpmc_pkg::PRESS_M1;
				mode_d  = wpmc_pkg::MODE_NONE;
			end
			wpmc_pkg::REQ_TICK: begin
				if (extraction) begin
					if (item.safety_alert) begin
						pump_d = 1'b0;
					end else if (cur_ent.press == wpmc_pkg::PRESS_M2) begin
						if (item.pressure_mbar < cfg.demand_pres) begin
							if (!demand_q) begin
								demand_d    = 1'b1;
								dem_start_d = item.now_ms;
							end else if (fault_due) begin
								press_d = wpmc_pkg::PRESS_M1;
								pump_d  = 1'b0;
								cut     = 1'b1;
							end
						end else begin
							demand_d    = 1'b0;
							dem_start_d = '0;
						end
					end else if (cur_ent.press == wpmc_pkg::PRESS_M3) begin
						// hysteresis, gated by the minimum switching interval
						if (!pump_q && item.pressure_mbar < cfg.pump_on && may_switch) begin
							pump_d    = 1'b1;
							press_d   = wpmc_pkg::PRESS_M3;
							last_sw_d = item.now_ms;
						end else if (pump_q && item.pressure_mbar > cfg.pump_off
						             && may_switch) begin
							pump_d    = 1'b0;
							last_sw_d = item.now_ms;
						end
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= wpmc_pkg::MODE_NONE;
			pump_q      <= 1'b0;
			v1_q        <= 1'b0;
			v2_q        <= 1'b0;
			press_q     <= wpmc_pkg::PRESS_M1;
			last_sw_q   <= '0;
			demand_q    <= 1'b0;
			dem_start_q <= '0;
		end else if (step) begin
			mode_q      <= mode_d;
			pump_q      <= pump_d;
			v1_q        <= v1_d;
			v2_q        <= v2_d;
			press_q     <= press_d;
			last_sw_q   <= last_sw_d;
			demand_q    <= demand_d;
			dem_start_q <= dem_start_d;
		end
	end

	always_comb begin
		res.valve_one    = v1_d;
		res.valve_two    = v2_d;
		res.pump_drive   = pump_d;
		res.press_select = press_d;
		res.mode_now     = mode_d;
		res.fault_cut    = cut;
	end

endmodule
`default_nettype wire

FILE: rtl/wpmc_checker.sv
// port-level checks for the water pump mode controller, bound to the top level
// depends on wpmc_pkg and water_pump_mode_controller_unit
`timescale 1ns / 1ps
`default_nettype none
module wpmc_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             out_valid,
	input wire logic                             out_ready,
	input wire logic                             valve_one,
	input wire logic                             valve_two,
	input wire logic                             pump_drive,
	input wire logic [1:0]                       press_select,
	input wire logic [3:0]                       mode_now,
	input wire logic                             fault_cut
);

	// a stalled result item keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable({valve_one, valve_two,
		pump_drive, press_select, mode_now, fault_cut}))
		else $error("result item changed while stalled");

	// a fault cut leaves the pump off and the switch in M1
	a_cut_safe: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fault_cut |-> !pump_drive && press_select == wpmc_pkg::PRESS_M1)
		else $error("fault cut without safe pump and switch");

	// with no mode active everything is closed and off
	a_none_safe: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mode_now == wpmc_pkg::MODE_NONE |->
		!valve_one && !valve_two && !pump_drive && press_select == wpmc_pkg::PRESS_M1)
		else $error("outputs active with no mode");

	// only the hysteresis modes ever run the pump
	a_pump_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pump_drive |->
		mode_now == wpmc_pkg::MODE_E1C || mode_now == wpmc_pkg::MODE_E2C)
		else $error("pump on outside a hysteresis mode");

endmodule

bind water_pump_mode_controller_unit wpmc_checker u_wpmc_checker (.*);
`default_nettype wire
